// ----- sv/lrs_pkg.sv -----
package lrs_pkg;

    localparam int SIZE        = 64;
    localparam int IDX_W       = $clog2(SIZE);
    localparam int CNT_W       = $clog2(SIZE + 2);
    localparam int VAL_W       = 31;
    localparam int RADIX       = 10;
    localparam int DIG_W       = 4;
    localparam int PROD_W      = 63;
    localparam int RECIP_SHIFT = 35;
    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_COUNT,
        OP_PLACE,
        OP_COPY,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] addr;
        logic             rd_last;
        logic             load;
        logic             clr;
        logic             prefix;
        logic [DIG_W-1:0] pidx;
        logic             mdiv;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             maxq_zero;
        logic             out_ack;
    } sts_t;

endpackage

// ----- sv/lrs_datapath.sv -----
module lrs_datapath
    import lrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [VAL_W-1:0] s_value,
    input  logic             s_is_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_sorted_value,
    output logic [IDX_W-1:0] m_position,
    output logic             m_last_out
);

    logic [2*VAL_W-1:0] main_mem [SIZE];
    logic [2*VAL_W-1:0] scr_mem  [SIZE];
    logic [DIG_W-1:0]   dig_mem  [SIZE];

    logic [2*VAL_W-1:0] main_rd_reg, scr_rd_reg;
    logic [DIG_W-1:0]   dig_rd_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] max_reg, max_next;
    logic [VAL_W-1:0] maxq_reg, maxq_next;
    logic [CNT_W-1:0] counts_reg [RADIX];
    logic [CNT_W-1:0] counts_next [RADIX];

    logic             s1_vld_reg;
    op_t              s1_op_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    logic             s1_last_reg;

    logic              s2_vld_reg;
    logic [IDX_W-1:0]  s2_addr_reg;
    logic [VAL_W-1:0]  s2_val_reg, s2_q_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              out_vld_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic [IDX_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    logic               main_we, scr_we, dig_we;
    logic [IDX_W-1:0]   main_wa, scr_wa;
    logic [2*VAL_W-1:0] main_wd;
    logic [VAL_W-1:0]   q10, rem_full;
    logic [DIG_W-1:0]   dig;
    logic [CNT_W-1:0]   place_pos;
    logic [PROD_W-1:0]  mq_prod;
    logic               store_ok, out_ack;

    assign store_ok  = cnt_reg < CNT_W'(SIZE);
    assign q10       = VAL_W'(prod_reg[PROD_W-1:RECIP_SHIFT]);
    assign rem_full  = s2_q_reg - ((q10 << 3) + (q10 << 1));
    assign dig       = rem_full[DIG_W-1:0];
    assign place_pos = counts_reg[dig_rd_reg] - CNT_W'(1);
    assign mq_prod   = PROD_W'(maxq_reg) * PROD_W'(RECIP);
    assign out_ack   = out_vld_reg && m_ready;

    always_comb begin
        main_we = 1'b0;
        main_wa = '0;
        main_wd = '0;
        dig_we  = 1'b0;
        if (cmd.load && store_ok) begin
            main_we = 1'b1;
            main_wa = cnt_reg[IDX_W-1:0];
            main_wd = {s_value, s_value};
        end else if (s2_vld_reg) begin
            main_we = 1'b1;
            dig_we  = 1'b1;
            main_wa = s2_addr_reg;
            main_wd = {s2_val_reg, q10};
        end else if (s1_vld_reg && s1_op_reg == OP_COPY) begin
            main_we = 1'b1;
            main_wa = s1_addr_reg;
            main_wd = scr_rd_reg;
        end
        scr_we = s1_vld_reg && s1_op_reg == OP_PLACE;
        scr_wa = place_pos[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (main_we) begin
            main_mem[main_wa] <= main_wd;
        end
        if (dig_we) begin
            dig_mem[main_wa] <= dig;
        end
        if (scr_we) begin
            scr_mem[scr_wa] <= main_rd_reg;
        end
        main_rd_reg <= main_mem[cmd.addr];
        scr_rd_reg  <= scr_mem[cmd.addr];
        dig_rd_reg  <= dig_mem[cmd.addr];
    end

    always_comb begin
        cnt_next  = cnt_reg;
        max_next  = max_reg;
        maxq_next = maxq_reg;
        if (cmd.load && store_ok) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (s_value > max_reg) begin
                max_next = s_value;
            end
        end
        if (cmd.load && s_is_last) begin
            maxq_next = max_next;
        end
        if (cmd.mdiv) begin
            maxq_next = VAL_W'(mq_prod[PROD_W-1:RECIP_SHIFT]);
        end
        if (cmd.finish) begin
            cnt_next = '0;
            max_next = '0;
        end
    end

    always_comb begin
        counts_next = counts_reg;
        if (cmd.clr) begin
            for (int i = 0; i < RADIX; i++) begin
                counts_next[i] = '0;
            end
        end else if (s2_vld_reg) begin
            counts_next[dig] = counts_reg[dig] + CNT_W'(1);
        end else if (cmd.prefix) begin
            counts_next[cmd.pidx] = counts_reg[cmd.pidx] + counts_reg[cmd.pidx - DIG_W'(1)];
        end else if (s1_vld_reg && s1_op_reg == OP_PLACE) begin
            counts_next[dig_rd_reg] = place_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            max_reg     <= '0;
            maxq_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < RADIX; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            cnt_reg    <= cnt_next;
            max_reg    <= max_next;
            maxq_reg   <= maxq_next;
            counts_reg <= counts_next;
            s1_vld_reg <= cmd.op != OP_NONE;
            s2_vld_reg <= s1_vld_reg && s1_op_reg == OP_COUNT;
            if (s1_vld_reg && s1_op_reg == OP_READ) begin
                out_vld_reg <= 1'b1;
            end else if (out_ack) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg   <= cmd.op;
        s1_addr_reg <= cmd.addr;
        s1_last_reg <= cmd.rd_last;
        s2_addr_reg <= s1_addr_reg;
        s2_val_reg  <= main_rd_reg[2*VAL_W-1:VAL_W];
        s2_q_reg    <= main_rd_reg[VAL_W-1:0];
        prod_reg    <= PROD_W'(main_rd_reg[VAL_W-1:0]) * PROD_W'(RECIP);
        if (s1_vld_reg && s1_op_reg == OP_READ) begin
            out_val_reg  <= main_rd_reg[2*VAL_W-1:VAL_W];
            out_pos_reg  <= s1_addr_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign sts.n          = cnt_reg;
    assign sts.maxq_zero  = maxq_reg == '0;
    assign sts.out_ack    = out_ack;
    assign m_valid        = out_vld_reg;
    assign m_sorted_value = out_val_reg;
    assign m_position     = out_pos_reg;
    assign m_last_out     = out_last_reg;

endmodule

// ----- sv/lrs_ctrl.sv -----
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_is_last,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_COUNT,
        S_PREFIX,
        S_PLACE,
        S_COPY,
        S_READ,
        S_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rev_addr;

    assign rev_addr = sts.n - CNT_W'(1) - cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_is_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cnt_next = '0;
                if (sts.maxq_zero) begin
                    state_next = S_READ;
                end else begin
                    cmd.clr    = 1'b1;
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                if (cnt_reg < sts.n) begin
                    cmd.op   = OP_COUNT;
                    cmd.addr = cnt_reg[IDX_W-1:0];
                end
                if (cnt_reg == sts.n + CNT_W'(1)) begin
                    cnt_next   = CNT_W'(1);
                    state_next = S_PREFIX;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_PREFIX: begin
                cmd.prefix = 1'b1;
                cmd.pidx   = cnt_reg[DIG_W-1:0];
                if (cnt_reg == CNT_W'(RADIX - 1)) begin
                    cnt_next   = '0;
                    state_next = S_PLACE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_PLACE: begin
                if (cnt_reg < sts.n) begin
                    cmd.op   = OP_PLACE;
                    cmd.addr = rev_addr[IDX_W-1:0];
                end
                if (cnt_reg == sts.n) begin
                    cnt_next   = '0;
                    state_next = S_COPY;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_COPY: begin
                if (cnt_reg < sts.n) begin
                    cmd.op   = OP_COPY;
                    cmd.addr = cnt_reg[IDX_W-1:0];
                end
                if (cnt_reg == sts.n) begin
                    cmd.mdiv   = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_READ: begin
                cmd.op      = OP_READ;
                cmd.addr    = cnt_reg[IDX_W-1:0];
                cmd.rd_last = cnt_reg == sts.n - CNT_W'(1);
                state_next  = S_WAIT;
            end
            S_WAIT: begin
                if (sts.out_ack) begin
                    if (cnt_reg == sts.n - CNT_W'(1)) begin
                        cmd.finish = 1'b1;
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end else begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- sv/lsd_decimal_radix_sort.sv -----
// Channel | Ports                                            | Transaction
// input   | s_valid s_ready s_value s_is_last                | one value to load
// result  | m_valid m_ready m_sorted_value m_position m_last_out | one sorted value
// Loading takes one value per cycle; s_is_last starts the sort.
// Each decimal pass runs count, prefix, place and copy sweeps for n values (the count,
// place and copy sweeps read one memory port each); up to ten passes, stopped when max/place is zero.
// Results leave one at a time: the next is read only once m_ready has taken the last one.
// aresetn is synchronous, active low; the stores need no clearing after it.
// No value is taken while a sort runs or results are pending.
module lsd_decimal_radix_sort
    import lrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_value,
    input  logic             s_is_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_sorted_value,
    output logic [IDX_W-1:0] m_position,
    output logic             m_last_out
);

    cmd_t cmd;
    sts_t sts;

    lrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lrs_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_value        (s_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_position     (m_position),
        .m_last_out     (m_last_out)
    );

endmodule

// ----- sv/lrs_checker.sv -----
module lrs_checker
    import lrs_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_is_last,
    input logic             m_valid,
    input logic             m_ready,
    input logic [VAL_W-1:0] m_sorted_value,
    input logic             m_last_out
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input open while results pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_last |=> !s_ready)
        else $error("input open after last value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_out |=> s_ready && !m_valid)
        else $error("no return to loading after final result");

endmodule

bind lsd_decimal_radix_sort lrs_checker u_lrs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_is_last      (s_is_last),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sorted_value (m_sorted_value),
    .m_last_out     (m_last_out)
);
